// ----- sv/bbr_pkg.sv -----
// Shared types and constants of the bounding box rotation block.
// No dependencies; imported by bbr_geom, bbr_norm and bounding_box_rotate_top.
package bbr_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_COS    = 3'd0;
    localparam logic [2:0] REG_SIN    = 3'd1;
    localparam logic [2:0] REG_IN_W   = 3'd2;
    localparam logic [2:0] REG_IN_H   = 3'd3;
    localparam logic [2:0] REG_OUT_W  = 3'd4;
    localparam logic [2:0] REG_OUT_H  = 3'd5;
    localparam logic [2:0] REG_OPTS   = 3'd6;
    localparam logic [2:0] REG_THRESH = 3'd7;

    // Option bits and modes
    localparam int         OPT_XYWH   = 2;
    localparam int         OPT_NORM   = 3;
    localparam logic [1:0] MODE_FIXED = 2'd1;
    localparam logic [1:0] MODE_HALF  = 2'd2;

    localparam logic [30:0] OUT_MAX = 31'h7FFF_FFFF;

    typedef struct packed {
        logic signed [15:0] cos_a;
        logic signed [15:0] sin_a;
        logic [14:0]        in_w;
        logic [14:0]        in_h;
        logic [14:0]        out_w;
        logic [14:0]        out_h;
        logic [3:0]         opt;
        logic [16:0]        thr;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        cos_a: 16'sd16384, sin_a: 16'sd0,
        in_w: 15'd1, in_h: 15'd1, out_w: 15'd1, out_h: 15'd1,
        opt: 4'd8, thr: 17'd6554
    };

endpackage

// ----- sv/bbr_mul.sv -----
// Two-stage unsigned multiplier built from four registered partial products.
// Depends on nothing; used by bbr_area.
module bbr_mul #(
    parameter int WA = 32,
    parameter int WB = 32
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [WA-1:0]      i_a,
    input  logic [WB-1:0]      i_b,
    output logic [WA+WB-1:0]   o_p
);
    localparam int LA = WA / 2;
    localparam int LB = WB / 2;
    localparam int WP = WA + WB;

    logic [LA+LB-1:0]           r_ll;
    logic [LA+(WB-LB)-1:0]      r_lh;
    logic [(WA-LA)+LB-1:0]      r_hl;
    logic [(WA-LA)+(WB-LB)-1:0] r_hh;
    logic [WP-1:0]              r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= i_a[LA-1:0]  * i_b[LB-1:0];
            r_lh <= i_a[LA-1:0]  * i_b[WB-1:LB];
            r_hl <= i_a[WA-1:LA] * i_b[LB-1:0];
            r_hh <= i_a[WA-1:LA] * i_b[WB-1:LB];
            r_p  <= WP'(r_ll) + (WP'(r_lh) << LB) + (WP'(r_hl) << LA)
                  + (WP'(r_hh) << (LA + LB));
        end
    end

    assign o_p = r_p;
endmodule

// ----- sv/bbr_geom.sv -----
// Geometry pipeline: centring, rotation, enclosing box, expansion correction, clip.
// Depends on bbr_pkg; feeds bbr_area. Eleven register stages.
module bbr_geom #(
    parameter int FRAC_BITS  = 16,
    parameter int INDEX_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [15:0]                 i_idx,
    input  logic signed [31:0]          i_a,
    input  logic signed [31:0]          i_b,
    input  logic signed [31:0]          i_c,
    input  logic signed [31:0]          i_d,
    input  bbr_pkg::t_cfg               i_cfg,
    output logic                        o_valid,
    output logic                        o_drop,
    output logic [15:0]                 o_idx,
    output logic [FRAC_BITS+22:0]       o_w0m,
    output logic [FRAC_BITS+22:0]       o_h0m,
    output logic [FRAC_BITS+14:0]       o_nwm,
    output logic [FRAC_BITS+14:0]       o_nhm,
    output logic signed [FRAC_BITS+16:0] o_v [4]
);
    import bbr_pkg::*;

    localparam int F  = FRAC_BITS;
    localparam int WE = 50;          // centring product
    localparam int WC = F + 19;      // saturated centred coordinate
    localparam int WP = WC + 16;     // rotation product
    localparam int WR = F + 24;      // rotated canvas coordinate
    localparam int WK = F + 17;      // clipped coordinate
    localparam int WM = F + 23;
    localparam int WN = F + 15;
    localparam int NS = 11;

    localparam logic [15:0] IDX_MASK = (INDEX_BITS >= 16) ? 16'hFFFF
                                     : 16'((32'd1 << INDEX_BITS) - 32'd1);
    localparam logic signed [33:0]   HALF34 = 34'(1) << (F - 1);
    localparam logic signed [WE-1:0] LIM    = WE'(1) << (F + 17);

    logic [NS:1]        r_v;
    logic [15:0]        r_idx [NS:1];

    logic signed [32:0]   r1_p [4];
    logic signed [WE-1:0] r2_e [4], n2_e [4];
    logic signed [WC-1:0] r3_c [4], n3_c [4];
    logic signed [WP-1:0] r4_xc [2], r4_xs [2], r4_yc [2], r4_ys [2];
    logic signed [WC:0]   r4_ow, r4_oh, r5_ow, r5_oh, r6_ow, r6_oh, r7_ow, r7_oh;
    logic signed [WP:0]   r5_sx [4], r5_sy [4], n5_sx [4], n5_sy [4];
    logic signed [WR-1:0] r6_rx [4], r6_ry [4], n6_rx [4], n6_ry [4];
    logic signed [WR-1:0] r7_x1, r7_x2, r7_y1, r7_y2, n7_x1, n7_x2, n7_y1, n7_y2;
    logic signed [WR-1:0] r8_x1, r8_x2, r8_y1, r8_y2, r8_ew, r8_eh;
    logic signed [WR-1:0] n8_pw, n8_ph;
    logic                 n8_flip;
    logic signed [WR-1:0] r9_x1, r9_x2, r9_y1, r9_y2, n9_dw, n9_dh;
    logic signed [WR-1:0] r10_w0, r10_h0, n10_w0, n10_h0;
    logic signed [WK-1:0] r10_cx1, r10_cx2, r10_cy1, r10_cy2;
    logic                 r10_drop;
    logic [WK-1:0]        n10_cw, n10_ch;
    logic signed [WK-1:0] n11_nw, n11_nh;
    logic signed [WR-1:0] n11_w0a, n11_h0a;
    logic signed [WK-1:0] n11_nwa, n11_nha;
    logic                 r11_drop;
    logic [WM-1:0]        r11_w0m, r11_h0m;
    logic [WN-1:0]        r11_nwm, r11_nhm;
    logic signed [WK-1:0] r11_v [4];

    function automatic logic signed [WK-1:0] clip(input logic signed [WR-1:0] v,
                                                  input logic [WK-1:0] lim);
        logic signed [WK-1:0] res;
        if (v < 0)
            res = '0;
        else if (v > $signed(WR'(lim)))
            res = $signed(lim);
        else
            res = v[WK-1:0];
        return res;
    endfunction

    // centring and saturation
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            logic [14:0] sz;
            sz = (j % 2 == 0) ? i_cfg.in_w : i_cfg.in_h;
            if (i_cfg.opt[OPT_NORM])
                n2_e[j] = (34'(r1_p[j]) - HALF34) * $signed({1'b0, sz});
            else
                n2_e[j] = WE'(r1_p[j]) - $signed(WE'(sz) << (F - 1));
            if (r2_e[j] > LIM)
                n3_c[j] = WC'(LIM);
            else if (r2_e[j] < -LIM)
                n3_c[j] = WC'(-LIM);
            else
                n3_c[j] = r2_e[j][WC-1:0];
        end
    end

    // corner i: x from r3 index 2*(i&1), y from 2*(i>>1)+1
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            logic signed [WP:0] sh_x, sh_y;
            n5_sx[i] = r4_xc[i % 2] + r4_ys[i / 2] + 8192;
            n5_sy[i] = r4_yc[i / 2] - r4_xs[i % 2] + 8192;
            sh_x = r5_sx[i] >>> 14;
            sh_y = r5_sy[i] >>> 14;
            n6_rx[i] = $signed(sh_x[WR-1:0]) + $signed(WR'(i_cfg.out_w) << (F - 1));
            n6_ry[i] = $signed(sh_y[WR-1:0]) + $signed(WR'(i_cfg.out_h) << (F - 1));
        end
        n7_x1 = r6_rx[0]; n7_x2 = r6_rx[0];
        n7_y1 = r6_ry[0]; n7_y2 = r6_ry[0];
        for (int i = 1; i < 4; i++) begin
            if (r6_rx[i] < n7_x1) n7_x1 = r6_rx[i];
            if (r6_rx[i] > n7_x2) n7_x2 = r6_rx[i];
            if (r6_ry[i] < n7_y1) n7_y1 = r6_ry[i];
            if (r6_ry[i] > n7_y2) n7_y2 = r6_ry[i];
        end
    end

    // expansion correction, clip, area prerequisites
    always_comb begin
        n8_pw   = r7_x2 - r7_x1;
        n8_ph   = r7_y2 - r7_y1;
        n8_flip = (r7_ow < r7_oh) != (n8_pw < n8_ph);
        case (i_cfg.opt[1:0])
            MODE_FIXED: begin
                n9_dw = r8_ew >>> 1;
                n9_dh = r8_eh >>> 1;
            end
            MODE_HALF: begin
                n9_dw = r8_ew >>> 2;
                n9_dh = r8_eh >>> 2;
            end
            default: begin
                n9_dw = '0;
                n9_dh = '0;
            end
        endcase
        n10_w0  = r9_x2 - r9_x1;
        n10_h0  = r9_y2 - r9_y1;
        n10_cw  = WK'(i_cfg.out_w) << F;
        n10_ch  = WK'(i_cfg.out_h) << F;
        n11_nw  = r10_cx2 - r10_cx1;
        n11_nh  = r10_cy2 - r10_cy1;
        n11_w0a = (r10_w0 < 0) ? -r10_w0 : r10_w0;
        n11_h0a = (r10_h0 < 0) ? -r10_h0 : r10_h0;
        n11_nwa = (n11_nw < 0) ? -n11_nw : n11_nw;
        n11_nha = (n11_nh < 0) ? -n11_nh : n11_nh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NS-1:1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_idx[1] <= i_idx & IDX_MASK;
            for (int k = 2; k <= NS; k++)
                r_idx[k] <= r_idx[k-1];

            r1_p[0] <= 33'(i_a);
            r1_p[1] <= 33'(i_b);
            r1_p[2] <= i_cfg.opt[OPT_XYWH] ? 33'(i_c) + 33'(i_a) : 33'(i_c);
            r1_p[3] <= i_cfg.opt[OPT_XYWH] ? 33'(i_d) + 33'(i_b) : 33'(i_d);

            r2_e <= n2_e;
            r3_c <= n3_c;

            for (int j = 0; j < 2; j++) begin
                r4_xc[j] <= r3_c[2*j]   * i_cfg.cos_a;
                r4_xs[j] <= r3_c[2*j]   * i_cfg.sin_a;
                r4_yc[j] <= r3_c[2*j+1] * i_cfg.cos_a;
                r4_ys[j] <= r3_c[2*j+1] * i_cfg.sin_a;
            end
            r4_ow <= (WC+1)'(r3_c[2]) - (WC+1)'(r3_c[0]);
            r4_oh <= (WC+1)'(r3_c[3]) - (WC+1)'(r3_c[1]);

            r5_sx <= n5_sx;  r5_sy <= n5_sy;
            r5_ow <= r4_ow;  r5_oh <= r4_oh;
            r6_rx <= n6_rx;  r6_ry <= n6_ry;
            r6_ow <= r5_ow;  r6_oh <= r5_oh;
            r7_x1 <= n7_x1;  r7_x2 <= n7_x2;
            r7_y1 <= n7_y1;  r7_y2 <= n7_y2;
            r7_ow <= r6_ow;  r7_oh <= r6_oh;

            r8_x1 <= r7_x1;  r8_x2 <= r7_x2;
            r8_y1 <= r7_y1;  r8_y2 <= r7_y2;
            r8_ew <= n8_pw - (n8_flip ? WR'(r7_oh) : WR'(r7_ow));
            r8_eh <= n8_ph - (n8_flip ? WR'(r7_ow) : WR'(r7_oh));

            r9_x1 <= r8_x1 + n9_dw;  r9_x2 <= r8_x2 - n9_dw;
            r9_y1 <= r8_y1 + n9_dh;  r9_y2 <= r8_y2 - n9_dh;

            r10_w0   <= n10_w0;
            r10_h0   <= n10_h0;
            r10_drop <= (n10_w0 == 0) || (n10_h0 == 0) || (n10_w0[WR-1] != n10_h0[WR-1]);
            r10_cx1  <= clip(r9_x1, n10_cw);
            r10_cx2  <= clip(r9_x2, n10_cw);
            r10_cy1  <= clip(r9_y1, n10_ch);
            r10_cy2  <= clip(r9_y2, n10_ch);

            r11_drop <= r10_drop || ((n11_nw != 0) && (n11_nh != 0)
                                     && (n11_nw[WK-1] != n11_nh[WK-1]));
            r11_w0m  <= n11_w0a[WM-1:0];
            r11_h0m  <= n11_h0a[WM-1:0];
            r11_nwm  <= n11_nwa[WN-1:0];
            r11_nhm  <= n11_nha[WN-1:0];
            r11_v[0] <= r10_cx1;
            r11_v[1] <= r10_cy1;
            r11_v[2] <= i_cfg.opt[OPT_XYWH] ? n11_nw : r10_cx2;
            r11_v[3] <= i_cfg.opt[OPT_XYWH] ? n11_nh : r10_cy2;
        end
    end

    assign o_valid = r_v[NS];
    assign o_idx   = r_idx[NS];
    assign o_drop  = r11_drop;
    assign o_w0m   = r11_w0m;
    assign o_h0m   = r11_h0m;
    assign o_nwm   = r11_nwm;
    assign o_nhm   = r11_nhm;
    assign o_v     = r11_v;
endmodule

// ----- sv/bbr_area.sv -----
// Kept-area test: clipped area * 65536 against threshold * original area.
// Depends on bbr_mul; five register stages, drops boxes that fail.
module bbr_area #(
    parameter int WA = 39,
    parameter int WN = 31,
    parameter int PW = 144
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic           i_drop,
    input  logic [WA-1:0]  i_w0m,
    input  logic [WA-1:0]  i_h0m,
    input  logic [WN-1:0]  i_nwm,
    input  logic [WN-1:0]  i_nhm,
    input  logic [16:0]    i_thr,
    input  logic [PW-1:0]  i_pay,
    output logic           o_valid,
    output logic [PW-1:0]  o_pay
);
    localparam int WQ = 2 * WA + 17;

    logic [WA+16:0]   w_p1;
    logic [2*WN-1:0]  w_pn;
    logic [WQ-1:0]    w_p2;
    logic [WA-1:0]    r_h0d [2];
    logic [2*WN-1:0]  r_pnd [2];
    logic [3:0]       r_v;
    logic [3:0]       r_d;
    logic [PW-1:0]    r_pay [4];
    logic             r_out_v;
    logic [PW-1:0]    r_out_pay;

    bbr_mul #(.WA(WA), .WB(17)) u_mul_old (
        .i_clk(i_clk), .i_en(i_en), .i_a(i_w0m), .i_b(i_thr), .o_p(w_p1)
    );

    bbr_mul #(.WA(WN), .WB(WN)) u_mul_new (
        .i_clk(i_clk), .i_en(i_en), .i_a(i_nwm), .i_b(i_nhm), .o_p(w_pn)
    );

    bbr_mul #(.WA(WA + 17), .WB(WA)) u_mul_old2 (
        .i_clk(i_clk), .i_en(i_en), .i_a(w_p1), .i_b(r_h0d[1]), .o_p(w_p2)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            r_out_v <= 1'b0;
        end else if (i_en) begin
            r_v     <= {r_v[2:0], i_valid};
            r_out_v <= r_v[3] && !r_d[3] && (WQ'({r_pnd[1], 16'd0}) >= w_p2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_h0d[0]  <= i_h0m;
            r_h0d[1]  <= r_h0d[0];
            r_pnd[0]  <= w_pn;
            r_pnd[1]  <= r_pnd[0];
            r_d       <= {r_d[2:0], i_drop};
            r_pay[0]  <= i_pay;
            for (int k = 1; k < 4; k++)
                r_pay[k] <= r_pay[k-1];
            r_out_pay <= r_pay[3];
        end
    end

    assign o_valid = r_out_v;
    assign o_pay   = r_out_pay;
endmodule

// ----- sv/bbr_norm.sv -----
// Output formatting: clamp at zero, then saturation or normalization by the
// canvas size; restoring divider, one quotient bit per stage. Depends on bbr_pkg.
module bbr_norm #(
    parameter int FRAC_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [15:0]                  i_idx,
    input  logic signed [FRAC_BITS+16:0] i_v [4],
    input  bbr_pkg::t_cfg                i_cfg,
    output logic                         o_valid,
    output logic [15:0]                  o_idx,
    output logic [30:0]                  o_r [4]
);
    import bbr_pkg::*;

    localparam int F  = FRAC_BITS;
    localparam int QB = F + 1;       // quotient bits, value never above one
    localparam int WU = F + 16;
    localparam int WQ = F + 17;
    localparam int WX = (WU > 31) ? WU : 31;

    logic [QB:0]     r_v;
    logic [15:0]     r_idx [QB+1];
    logic [WQ-1:0]   r_rem [QB+1][4];
    logic [QB-1:0]   r_q   [QB+1][4];
    logic [14:0]     r_dv  [QB+1][4];
    logic [30:0]     r_byp [QB+1][4];

    logic [WU-1:0]   n_vp  [4];
    logic [14:0]     n_dv  [4];
    logic [WX-1:0]   n_vx  [4];

    always_comb begin
        for (int l = 0; l < 4; l++) begin
            logic [14:0] sz;
            sz      = (l % 2 == 0) ? i_cfg.out_w : i_cfg.out_h;
            n_dv[l] = (sz == '0) ? 15'd1 : sz;
            n_vp[l] = (i_v[l] < 0) ? '0 : i_v[l][WU-1:0];
            n_vx[l] = WX'(n_vp[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[QB-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_idx[0] <= i_idx;
            for (int l = 0; l < 4; l++) begin
                r_rem[0][l] <= WQ'(n_vp[l]) + WQ'(n_dv[l] >> 1);
                r_q[0][l]   <= '0;
                r_dv[0][l]  <= n_dv[l];
                r_byp[0][l] <= (n_vx[l] > WX'(OUT_MAX)) ? OUT_MAX : n_vx[l][30:0];
            end
            for (int k = 0; k < QB; k++) begin
                r_idx[k+1] <= r_idx[k];
                for (int l = 0; l < 4; l++) begin
                    r_dv[k+1][l]  <= r_dv[k][l];
                    r_byp[k+1][l] <= r_byp[k][l];
                    if (r_rem[k][l] >= (WQ'(r_dv[k][l]) << (QB - 1 - k))) begin
                        r_rem[k+1][l] <= r_rem[k][l] - (WQ'(r_dv[k][l]) << (QB - 1 - k));
                        r_q[k+1][l]   <= r_q[k][l] | (QB'(1) << (QB - 1 - k));
                    end else begin
                        r_rem[k+1][l] <= r_rem[k][l];
                        r_q[k+1][l]   <= r_q[k][l];
                    end
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < 4; l++)
            o_r[l] = i_cfg.opt[OPT_NORM] ? 31'(r_q[QB][l]) : r_byp[QB][l];
    end

    assign o_valid = r_v[QB];
    assign o_idx   = r_idx[QB];
endmodule

// ----- sv/bounding_box_rotate_top.sv -----
// Bounding box rotation: each box is centred on the input image, its corners
// rotated by the configured cosine and sine, the enclosing box recentred on the
// output canvas, optionally shrunk by the rotation expansion, clipped, tested
// for kept area and emitted in the input's form. One box enters per clock
// unless the output is blocked, passing eleven geometry stages, five area-test
// stages, the one-bit-per-stage normalization divider and the output register.
// Boxes that fail the tests leave no output. The user must write registers
// through the plain write port only while the block is idle (not enforced).
// Depends on bbr_pkg, bbr_geom, bbr_area, bbr_norm, bbr_mul.
module bounding_box_rotate_top #(
    parameter int FRAC_BITS  = 16,
    parameter int INDEX_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // box_index[15:0], coord_a[47:16], coord_b[79:48], coord_c[111:80],
    // coord_d[143:112]
    input  logic [143:0]  s_axis_tdata,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // source_index[15:0], result_a[46:16], result_b[77:47], result_c[108:78],
    // result_d[139:109], zero[143:140]
    output logic [143:0]  m_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    input  logic          i_cfg_wr_en,
    input  logic [2:0]    i_cfg_idx,
    input  logic [16:0]   i_cfg_wdata
);
    import bbr_pkg::*;

    localparam int WK = FRAC_BITS + 17;
    localparam int WM = FRAC_BITS + 23;
    localparam int WN = FRAC_BITS + 15;
    localparam int PW = 16 + 4 * WK;

    t_cfg                 r_cfg;
    logic                 w_en;

    logic                 w_g_valid, w_g_drop;
    logic [15:0]          w_g_idx;
    logic [WM-1:0]        w_g_w0m, w_g_h0m;
    logic [WN-1:0]        w_g_nwm, w_g_nhm;
    logic signed [WK-1:0] w_g_v [4];

    logic                 w_a_valid;
    logic [PW-1:0]        w_a_pay;
    logic signed [WK-1:0] w_a_v [4];

    logic                 w_n_valid;
    logic [15:0]          w_n_idx;
    logic [30:0]          w_n_r [4];

    logic                 r_out_valid;
    logic [15:0]          r_out_idx;
    logic [30:0]          r_out_r [4];

    // the pipeline moves unless a finished box is blocked at the output
    assign w_en          = !w_n_valid || !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                REG_COS:    r_cfg.cos_a <= $signed(i_cfg_wdata[15:0]);
                REG_SIN:    r_cfg.sin_a <= $signed(i_cfg_wdata[15:0]);
                REG_IN_W:   r_cfg.in_w  <= i_cfg_wdata[14:0];
                REG_IN_H:   r_cfg.in_h  <= i_cfg_wdata[14:0];
                REG_OUT_W:  r_cfg.out_w <= i_cfg_wdata[14:0];
                REG_OUT_H:  r_cfg.out_h <= i_cfg_wdata[14:0];
                REG_OPTS:   r_cfg.opt   <= i_cfg_wdata[3:0];
                REG_THRESH: r_cfg.thr   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    bbr_geom #(.FRAC_BITS(FRAC_BITS), .INDEX_BITS(INDEX_BITS)) u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (s_axis_tvalid),
        .i_idx   (s_axis_tdata[15:0]),
        .i_a     ($signed(s_axis_tdata[47:16])),
        .i_b     ($signed(s_axis_tdata[79:48])),
        .i_c     ($signed(s_axis_tdata[111:80])),
        .i_d     ($signed(s_axis_tdata[143:112])),
        .i_cfg   (r_cfg),
        .o_valid (w_g_valid),
        .o_drop  (w_g_drop),
        .o_idx   (w_g_idx),
        .o_w0m   (w_g_w0m),
        .o_h0m   (w_g_h0m),
        .o_nwm   (w_g_nwm),
        .o_nhm   (w_g_nhm),
        .o_v     (w_g_v)
    );

    bbr_area #(.WA(WM), .WN(WN), .PW(PW)) u_area (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_g_valid),
        .i_drop  (w_g_drop),
        .i_w0m   (w_g_w0m),
        .i_h0m   (w_g_h0m),
        .i_nwm   (w_g_nwm),
        .i_nhm   (w_g_nhm),
        .i_thr   (r_cfg.thr),
        .i_pay   ({w_g_v[3], w_g_v[2], w_g_v[1], w_g_v[0], w_g_idx}),
        .o_valid (w_a_valid),
        .o_pay   (w_a_pay)
    );

    always_comb begin
        for (int l = 0; l < 4; l++)
            w_a_v[l] = $signed(w_a_pay[16 + l*WK +: WK]);
    end

    bbr_norm #(.FRAC_BITS(FRAC_BITS)) u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_a_valid),
        .i_idx   (w_a_pay[15:0]),
        .i_v     (w_a_v),
        .i_cfg   (r_cfg),
        .o_valid (w_n_valid),
        .o_idx   (w_n_idx),
        .o_r     (w_n_r)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (m_axis_tready)
                r_out_valid <= 1'b0;
            if (w_en && w_n_valid)
                r_out_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && w_n_valid) begin
            r_out_idx <= w_n_idx;
            r_out_r   <= w_n_r;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out_r[3], r_out_r[2], r_out_r[1], r_out_r[0], r_out_idx};
endmodule

// ----- dv/tb_top.sv -----
// Testbench of bounding_box_rotate_top: directed and random boxes against a
// built-in rotation and clip predictor, with random stalls on both streams.
// Depends on bbr_pkg and the bounding_box_rotate_top RTL.
`timescale 1ns / 1ps

module tb_top;
    import bbr_pkg::*;

    logic         i_clk;
    logic         i_rst_n;
    logic [143:0] s_axis_tdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [143:0] m_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic         i_cfg_wr_en;
    logic [2:0]   i_cfg_idx;
    logic [16:0]  i_cfg_wdata;

    bounding_box_rotate_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tdata(s_axis_tdata), .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_idx(i_cfg_idx), .i_cfg_wdata(i_cfg_wdata)
    );

    localparam int DRAIN_CYCLES = 45;   // pipeline is 35 deep

    typedef struct {
        logic [143:0] data;
        bit           typed;     // result typed in below
        bit           kept;
        logic [143:0] box_out;
    } t_row;

    t_cfg         cfg;
    logic [143:0] boxes_due[$];
    int           mismatches = 0;
    bit           long_hold  = 0;
    bit           rx_choppy  = 0;
    int           burst_left = 1;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #3_000_000;
        $display("** bounding_box_rotate_top: FAILED **");
        $finish;
    end

    function automatic logic [143:0] pack_box_out(input logic [15:0] idx,
            input logic [30:0] a, input logic [30:0] b, input logic [30:0] c,
            input logic [30:0] d);
        return {4'd0, d, c, b, a, idx};
    endfunction

    function automatic longint centre_coord(input longint x, input longint size);
        longint v;
        longint lim;
        lim = longint'(1) <<< 33;
        if (cfg.opt[OPT_NORM])
            v = (x - 32768) * size;
        else
            v = x - (size <<< 15);
        if (v < -lim) v = -lim;
        if (v > lim) v = lim;
        return v;
    endfunction

    function automatic longint mag(input longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic logic [30:0] to_field(input longint v, input longint size);
        longint dv;
        if (v < 0) v = 0;
        if (cfg.opt[OPT_NORM]) begin
            dv = (size != 0) ? size : 1;
            v = (v + (dv >>> 1)) / dv;
        end
        if (v > longint'(OUT_MAX)) v = longint'(OUT_MAX);
        return v[30:0];
    endfunction

    // Returns 1 when the box survives; box_out then holds the expected transfer.
    function automatic bit rotate_box(input logic [143:0] din,
                                      output logic [143:0] box_out);
        longint a, b, c, d, cs, sn, ow, oh, cw, ch, x, y, rx, ry;
        longint x1, x2, y1, y2, pw, ph, dw, dh, w0, h0, nw, nh;
        longint xs[2], ys[2];
        logic [127:0] kept_area, min_area;
        logic [1:0] mode;
        bit flip;
        int sh;
        a = longint'($signed(din[47:16]));
        b = longint'($signed(din[79:48]));
        c = longint'($signed(din[111:80]));
        d = longint'($signed(din[143:112]));
        cs = longint'(cfg.cos_a);
        sn = longint'(cfg.sin_a);
        mode = cfg.opt[1:0];
        box_out = '0;
        if (cfg.opt[OPT_XYWH]) begin
            c = c + a;
            d = d + b;
        end
        xs[0] = centre_coord(a, longint'(cfg.in_w));
        xs[1] = centre_coord(c, longint'(cfg.in_w));
        ys[0] = centre_coord(b, longint'(cfg.in_h));
        ys[1] = centre_coord(d, longint'(cfg.in_h));
        ow = xs[1] - xs[0];
        oh = ys[1] - ys[0];
        cw = longint'(cfg.out_w) <<< 16;
        ch = longint'(cfg.out_h) <<< 16;
        x1 = 0; x2 = 0; y1 = 0; y2 = 0;
        for (int i = 0; i < 4; i++) begin
            x = xs[i & 1];
            y = ys[i >> 1];
            rx = ((x * cs + y * sn + 8192) >>> 14) + (cw >>> 1);
            ry = ((y * cs - x * sn + 8192) >>> 14) + (ch >>> 1);
            if (i == 0 || rx < x1) x1 = rx;
            if (i == 0 || rx > x2) x2 = rx;
            if (i == 0 || ry < y1) y1 = ry;
            if (i == 0 || ry > y2) y2 = ry;
        end
        if (mode == MODE_FIXED || mode == MODE_HALF) begin
            sh = (mode == MODE_HALF) ? 2 : 1;
            pw = x2 - x1;
            ph = y2 - y1;
            flip = (ow < oh) != (pw < ph);
            dw = (pw - (flip ? oh : ow)) >>> sh;
            dh = (ph - (flip ? ow : oh)) >>> sh;
            x1 += dw; x2 -= dw; y1 += dh; y2 -= dh;
        end
        w0 = x2 - x1;
        h0 = y2 - y1;
        if (w0 == 0 || h0 == 0 || ((w0 < 0) != (h0 < 0)))
            return 0;
        if (x1 < 0) x1 = 0; if (x1 > cw) x1 = cw;
        if (x2 < 0) x2 = 0; if (x2 > cw) x2 = cw;
        if (y1 < 0) y1 = 0; if (y1 > ch) y1 = ch;
        if (y2 < 0) y2 = 0; if (y2 > ch) y2 = ch;
        nw = x2 - x1;
        nh = y2 - y1;
        if (nw == 0 || nh == 0) begin
            if (cfg.thr != 0)
                return 0;
        end else begin
            if ((nw < 0) != (nh < 0))
                return 0;
            kept_area = 128'(mag(nw)) * 128'd65536 * 128'(mag(nh));
            min_area  = 128'(mag(w0)) * 128'(cfg.thr) * 128'(mag(h0));
            if (kept_area < min_area)
                return 0;
        end
        if (cfg.opt[OPT_XYWH]) begin
            x2 = nw;
            y2 = nh;
        end
        box_out = pack_box_out(din[15:0],
            to_field(x1, longint'(cfg.out_w)), to_field(y1, longint'(cfg.out_h)),
            to_field(x2, longint'(cfg.out_w)), to_field(y2, longint'(cfg.out_h)));
        return 1;
    endfunction

    // Output side: pattern of its own plus one counted long hold-off.
    always @(posedge i_clk) begin
        int hold_cnt;
        if (long_hold) begin
            long_hold = 0;
            hold_cnt = 300;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_axis_tready <= 1'b0;
        end else begin
            if ($urandom_range(0, 63) == 0)
                rx_choppy = ~rx_choppy;
            m_axis_tready <= rx_choppy ? ($urandom_range(0, 2) != 0) : 1'b1;
        end
    end

    always @(posedge i_clk) begin
        logic [143:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (boxes_due.size() == 0) begin
                $display("%0t: unexpected transfer, expected none, actual %h",
                         $time, m_axis_tdata);
                mismatches++;
            end else begin
                want = boxes_due.pop_front();
                if (want[15:0] !== m_axis_tdata[15:0]) begin
                    $display("%0t: source_index expected %h actual %h",
                             $time, want[15:0], m_axis_tdata[15:0]);
                    mismatches++;
                end
                if (want[46:16] !== m_axis_tdata[46:16]) begin
                    $display("%0t: result_a expected %h actual %h",
                             $time, want[46:16], m_axis_tdata[46:16]);
                    mismatches++;
                end
                if (want[77:47] !== m_axis_tdata[77:47]) begin
                    $display("%0t: result_b expected %h actual %h",
                             $time, want[77:47], m_axis_tdata[77:47]);
                    mismatches++;
                end
                if (want[108:78] !== m_axis_tdata[108:78]) begin
                    $display("%0t: result_c expected %h actual %h",
                             $time, want[108:78], m_axis_tdata[108:78]);
                    mismatches++;
                end
                if (want[139:109] !== m_axis_tdata[139:109]) begin
                    $display("%0t: result_d expected %h actual %h",
                             $time, want[139:109], m_axis_tdata[139:109]);
                    mismatches++;
                end
            end
        end
    end

    // Write enable stays high across back-to-back writes; the caller drops it.
    task automatic write_reg(input logic [2:0] idx, input logic [16:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            REG_COS:    cfg.cos_a = val[15:0];
            REG_SIN:    cfg.sin_a = val[15:0];
            REG_IN_W:   cfg.in_w  = val[14:0];
            REG_IN_H:   cfg.in_h  = val[14:0];
            REG_OUT_W:  cfg.out_w = val[14:0];
            REG_OUT_H:  cfg.out_h = val[14:0];
            REG_OPTS:   cfg.opt   = val[3:0];
            REG_THRESH: cfg.thr   = val;
            default: ;
        endcase
    endtask

    task automatic drain();
        while (boxes_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Offer one box, hold it until accepted, then maybe open a gap.
    task automatic send_box(input logic [143:0] din);
        logic [143:0] box_out;
        s_axis_tdata  <= din;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        if (rotate_box(din, box_out))
            boxes_due.insert(boxes_due.size(), box_out);
        if (--burst_left <= 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
    endtask

    function automatic logic [31:0] rand_coord(input longint span, input bit is_len);
        longint v;
        if (is_len)
            v = $urandom_range(0, 4) == 0 ? -longint'($urandom_range(0, 65536))
                                          : longint'($urandom) % (span + 1);
        else
            v = longint'($urandom) % (span + span / 2 + 1) - span / 4;
        return v[31:0];
    endfunction

    function automatic logic [143:0] make_box();
        logic [31:0] a, b, c, d;
        longint sw, shh;
        if ($urandom_range(0, 9) == 0)
            return {$urandom, $urandom, $urandom, $urandom, 16'($urandom)};
        sw  = cfg.opt[OPT_NORM] ? 65536 : (longint'(cfg.in_w) <<< 16);
        shh = cfg.opt[OPT_NORM] ? 65536 : (longint'(cfg.in_h) <<< 16);
        a = rand_coord(sw, 0);
        b = rand_coord(shh, 0);
        c = rand_coord(sw, cfg.opt[OPT_XYWH]);
        d = rand_coord(shh, cfg.opt[OPT_XYWH]);
        return {d, c, b, a, 16'($urandom)};
    endfunction

    function automatic logic [14:0] rand_size();
        return ($urandom_range(0, 7) == 0) ? 15'($urandom_range(1, 32767))
                                           : 15'($urandom_range(1, 640));
    endfunction

    initial begin
        t_row rows[$];
        t_row r;
        logic [143:0] box_out;
        logic [15:0] cs, sn;
        int pick;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_wdata   = '0;
        cfg           = CFG_RESET;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: 1x1 image and canvas, normalized corners, identity.
        r = '{{32'd65536, 32'd65536, 32'd0, 32'd0, 16'd1}, 1, 1,
              pack_box_out(16'd1, 31'd0, 31'd0, 31'd65536, 31'd65536)};
        rows.insert(rows.size(), r);
        r = '{{32'd65536, 32'd65536, 32'd0, 32'd0, 16'hFFFF}, 1, 1,
              pack_box_out(16'hFFFF, 31'd0, 31'd0, 31'd65536, 31'd65536)};
        rows.insert(rows.size(), r);
        // zero width
        r = '{{32'd65536, 32'd32768, 32'd0, 32'd32768, 16'd2}, 1, 0, '0};
        rows.insert(rows.size(), r);
        r = '{{{4{32'h7FFF_FFFF}}, 16'd3}, 1, 0, '0};
        rows.insert(rows.size(), r);
        r = '{{{4{32'h8000_0000}}, 16'd4}, 1, 0, '0};
        rows.insert(rows.size(), r);
        // fully off canvas: nothing left after clipping
        r = '{{32'd65536, 32'd196608, 32'd0, 32'd131072, 16'd5}, 1, 0, '0};
        rows.insert(rows.size(), r);
        r = '{{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 16'd6},
              0, 0, '0};
        rows.insert(rows.size(), r);
        r = '{{32'd65536, 32'd0, 32'd0, 32'd65536, 16'd7}, 0, 0, '0};
        rows.insert(rows.size(), r);
        r = '{{32'd65536, 32'd98304, 32'd0, 32'd32768, 16'd8}, 0, 0, '0};
        rows.insert(rows.size(), r);
        r = '{{32'hFFFF_0000, 32'd70000, 32'd1, 32'hFFFF_FFFF, 16'h5A5A}, 0, 0, '0};
        rows.insert(rows.size(), r);

        foreach (rows[i]) begin
            if (rows[i].typed) begin
                if (rotate_box(rows[i].data, box_out) != rows[i].kept ||
                    (rows[i].kept && box_out !== rows[i].box_out)) begin
                    $display("%0t: row %0d expected kept=%0d %h actual %h", $time, i,
                             rows[i].kept, rows[i].box_out, box_out);
                    mismatches++;
                end
            end
            send_box(rows[i].data);
        end
        s_axis_tvalid <= 1'b0;
        drain();

        for (int p = 0; p < 16; p++) begin
            pick = $urandom_range(0, 7);
            case (pick)
                0: begin cs = 16'sd16384;  sn = 16'sd0;      end
                1: begin cs = 16'sd0;      sn = 16'sd16384;  end
                2: begin cs = -16'sd16384; sn = 16'sd0;      end
                3: begin cs = 16'sd11585;  sn = -16'sd11585; end
                default: begin
                    cs = 16'($signed($urandom_range(0, 32768)) - 16384);
                    sn = 16'($signed($urandom_range(0, 32768)) - 16384);
                end
            endcase
            if (p == 0) begin cs = -16'sd16384; sn = 16'sd16384;  end
            if (p == 1) begin cs = 16'sd16384;  sn = -16'sd16384; end
            write_reg(REG_COS, {1'b0, cs});
            write_reg(REG_SIN, {1'b0, sn});
            write_reg(REG_IN_W,  p == 0 ? 17'd32767 : p == 1 ? 17'd1 : {2'b0, rand_size()});
            write_reg(REG_IN_H,  p == 0 ? 17'd32767 : p == 1 ? 17'd1 : {2'b0, rand_size()});
            write_reg(REG_OUT_W, p == 0 ? 17'd32767 : p == 1 ? 17'd1 : {2'b0, rand_size()});
            write_reg(REG_OUT_H, p == 0 ? 17'd32767 : p == 1 ? 17'd1 : {2'b0, rand_size()});
            write_reg(REG_OPTS, 17'(p));
            write_reg(REG_THRESH, p == 2 ? 17'd0 : p == 3 ? 17'd65536 :
                      ($urandom_range(0, 4) == 0 ? 17'd0 : 17'($urandom_range(0, 40000))));
            i_cfg_wr_en <= 1'b0;
            if (p == 4)
                long_hold = 1;
            for (int k = 0; k < 44; k++) begin
                if (p == 5 && k == 22) begin
                    s_axis_tvalid <= 1'b0;
                    do @(posedge i_clk); while (boxes_due.size() != 0);
                end
                send_box(make_box());
            end
            s_axis_tvalid <= 1'b0;
            drain();
        end

        if (mismatches == 0)
            $display("** bounding_box_rotate_top: PASSED **");
        else
            $display("** bounding_box_rotate_top: FAILED **");
        $finish;
    end

endmodule
